// ===== src/oal_pkg.sv =====
// Package for the ordered array list: request kinds, status codes and the
// per-cell control word. No dependencies.
package oal_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic take_left;
        logic take_right;
        logic take_new;
        logic tap;
    } t_cell_ctl;

endpackage

// ===== src/oal_cell.sv =====
// One storage cell of the ordered array list chain.
// Depends on oal_pkg for the cell control word.
module oal_cell #(
    parameter int WORD_BITS = 32
) (
    input  logic                  i_clk,
    input  oal_pkg::t_cell_ctl    i_ctl,
    input  logic [WORD_BITS-1:0]  i_left,
    input  logic [WORD_BITS-1:0]  i_right,
    input  logic [WORD_BITS-1:0]  i_new,
    output logic [WORD_BITS-1:0]  o_word,
    output logic [WORD_BITS-1:0]  o_tap
);
    import oal_pkg::*;

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        priority if (i_ctl.take_new) begin
            n_word = i_new;
        end else if (i_ctl.take_left) begin
            n_word = i_left;
        end else if (i_ctl.take_right) begin
            n_word = i_right;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_tap  = i_ctl.tap ? r_word : '0;

endmodule

// ===== src/ordered_array_list.sv =====
// Top level of the ordered array list: a chain of oal_cell registers plus
// length tracking and a registered result word.
// Depends on oal_pkg and oal_cell.

// Ordered list of up to CAPACITY words. Each request (insert, delete, read,
// clear) is applied on acceptance and its result word is registered, so one
// request per cycle is sustained while the consumer keeps up; the result
// shows in the cycle after acceptance. Insert and delete move every stored
// word at or above the position at once because each slot is its own cell
// register that loads from its left or right neighbor. Stored words are not
// cleared after reset; slots beyond the current length are never returned.
module ordered_array_list #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32,
    localparam int POS_BITS = $clog2(CAPACITY),
    localparam int CNT_BITS = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_kind,
    input  logic [POS_BITS-1:0]  i_position,
    input  logic [WORD_BITS-1:0] i_word_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WORD_BITS-1:0] o_word_out,
    output logic [1:0]           o_status,
    output logic [CNT_BITS-1:0]  o_count,
    output logic                 o_empty_res
);
    import oal_pkg::*;

    logic                 accept;
    t_kind                kind;
    logic                 full;
    logic [CNT_BITS-1:0]  pos_ext;
    logic                 ins_ok;
    logic                 del_ok;
    logic                 rd_ok;
    logic [1:0]           status;
    logic [CNT_BITS-1:0]  n_fill;
    logic [CNT_BITS-1:0]  r_fill;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_word_out;
    logic [1:0]           r_status;
    logic                 r_empty;
    logic [WORD_BITS-1:0] tap_or;

    logic [WORD_BITS-1:0] cell_word [CAPACITY];
    logic [WORD_BITS-1:0] cell_tap  [CAPACITY];
    t_cell_ctl            cell_ctl  [CAPACITY];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign kind       = t_kind'(i_kind);
    assign full       = (r_fill == CNT_BITS'(CAPACITY));
    assign pos_ext    = CNT_BITS'(i_position);

    assign ins_ok = (kind == KIND_INSERT) && !full && (pos_ext <= r_fill);
    assign del_ok = (kind == KIND_DELETE) && (pos_ext < r_fill);
    assign rd_ok  = (kind == KIND_READ) && (pos_ext < r_fill);

    always_comb begin
        status = ST_OK;
        n_fill = r_fill;
        unique case (kind)
            KIND_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else if (!ins_ok) begin
                    status = ST_RANGE;
                end else begin
                    n_fill = r_fill + CNT_BITS'(1);
                end
            end
            KIND_DELETE: begin
                if (!del_ok) begin
                    status = ST_RANGE;
                end else begin
                    n_fill = r_fill - CNT_BITS'(1);
                end
            end
            KIND_READ: begin
                if (!rd_ok) begin
                    status = ST_RANGE;
                end
            end
            KIND_CLEAR: begin
                n_fill = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                 here;
        logic                 above;
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        assign here  = (i_position == POS_BITS'(g));
        assign above = (POS_BITS'(g) > i_position);

        always_comb begin
            cell_ctl[g].take_new   = accept && ins_ok && here;
            cell_ctl[g].take_left  = accept && ins_ok && above;
            cell_ctl[g].take_right = accept && del_ok && (here || above);
            cell_ctl[g].tap        = here;
        end

        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_word[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_word[g+1];
        end

        oal_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_left  (left_w),
            .i_right (right_w),
            .i_new   (i_word_in),
            .o_word  (cell_word[g]),
            .o_tap   (cell_tap[g])
        );
    end

    always_comb begin
        tap_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            tap_or = tap_or | cell_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word_out <= (del_ok || rd_ok) ? tap_or : '0;
            r_status   <= status;
            r_empty    <= (n_fill == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word_out  = r_word_out;
    assign o_status    = r_status;
    assign o_count     = r_fill;
    assign o_empty_res = r_empty;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_BITS'(CAPACITY))
        else $error("list length beyond capacity");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_empty_res == (o_count == '0)))
        else $error("empty flag disagrees with count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (o_count == CNT_BITS'(CAPACITY)))
        else $error("full status with list not full");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_word_out == '0))
        else $error("rejected request returned a word");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ins_ok) |=> (r_fill == $past(r_fill) + CNT_BITS'(1)))
        else $error("insert did not grow the list");

endmodule
